### design/pfpp_pkg.sv
// ----------------------------------------------------------------------------
// Page framebuffer pixel plotter package
// Shared operation and color codes, plus the command and status structs that
// link the controller and the datapath.
// ----------------------------------------------------------------------------
package pfpp_pkg;

  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_BITMAP = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [1:0] ColorBlack   = 2'd0;
  localparam logic [1:0] ColorWhite   = 2'd1;
  localparam logic [1:0] ColorInverse = 2'd2;
  localparam logic [1:0] ColorNone    = 2'd3;

  localparam logic [2:0] LastBit = 3'd7;

  typedef struct packed {
    logic clr_we;
    logic start;
    logic calc;
    logic rd_en;
    logic wr_en;
    logic step_inc;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic last;
    logic is_read;
    logic out_busy;
  } ctrl_sts_t;

endpackage

### design/page_framebuffer_pixel_plotter.sv
// ----------------------------------------------------------------------------
// Page framebuffer pixel plotter
// Monochrome page-organized frame store with pixel, bitmap byte and readback.
//
// The slave stream carries one operation per transaction, with the operation
// code in tuser and its operands in tdata. The master stream returns one
// result per operation: the read byte and the count of pixels updated.
// The rotation register is written through cfg_we_i and cfg_wdata_i.
// After reset a clearing pass zeroes the store, one byte per cycle, until all
// PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes (1024 by default) are cleared; no
// operation is accepted until it ends.
// Each pixel has its coordinate mapped; when it lands on screen with a color
// other than none, its store byte is read and then written back, all through
// the single store port. The next operation can be accepted in the cycle
// after the result is loaded.
// The next operation is accepted while the previous result waits in the
// output register; when the receiver stalls, a finished operation waits for
// that register to empty.
// ----------------------------------------------------------------------------
module page_framebuffer_pixel_plotter #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[9:0], pos_y[19:10], color[21:20], pattern[29:22], invert[30],
  // byte_index[40:31], zero fill above.
  input  logic [47:0] s_axis_tdata,
  // operation[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], pixels_written[11:8], zero fill above.
  output logic [15:0] m_axis_tdata
);
  import pfpp_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  logic [7:0] read_data;
  logic [3:0] pixels_written;

  pfpp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfpp_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (s_axis_tuser),
    .pos_x_i          (s_axis_tdata[9:0]),
    .pos_y_i          (s_axis_tdata[19:10]),
    .color_i          (s_axis_tdata[21:20]),
    .pattern_i        (s_axis_tdata[29:22]),
    .invert_i         (s_axis_tdata[30]),
    .byte_index_i     (s_axis_tdata[40:31]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .read_data_o      (read_data),
    .pixels_written_o (pixels_written)
  );

  assign m_axis_tdata = {4'd0, pixels_written, read_data};

endmodule

### design/pfpp_datapath.sv
// ----------------------------------------------------------------------------
// Page framebuffer pixel plotter datapath
// Holds the frame store, the rotation register, the operand registers, the
// coordinate mapping and the result register.
// ----------------------------------------------------------------------------
module pfpp_datapath #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic [1:0]          operation_i,
  input  logic [9:0]          pos_x_i,
  input  logic [9:0]          pos_y_i,
  input  logic [1:0]          color_i,
  input  logic [7:0]          pattern_i,
  input  logic                invert_i,
  input  logic [9:0]          byte_index_i,
  input  pfpp_pkg::ctrl_cmd_t cmd_i,
  output pfpp_pkg::ctrl_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          read_data_o,
  output logic [3:0]          pixels_written_o
);
  import pfpp_pkg::*;

  localparam int Pages = (PANEL_HEIGHT + 7) / 8;
  localparam int Depth = PANEL_WIDTH * Pages;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = 12;
  localparam logic signed [10:0] Width11  = 11'(PANEL_WIDTH);
  localparam logic signed [10:0] Height11 = 11'(PANEL_HEIGHT);

  logic [7:0]    mem [Depth];

  logic [1:0]    rot_q;
  logic [AW-1:0] clr_q;
  logic          out_valid_q;

  op_e           op_q;
  logic [9:0]    x_q, y_q, bidx_q;
  logic [1:0]    color_q;
  logic [7:0]    pattern_q;
  logic          inv_q;
  logic [2:0]    step_q;
  logic [3:0]    count_q;
  logic [AW-1:0] idx_q;
  logic [7:0]    mask_q;
  logic [1:0]    col_q;
  logic          hit_q;
  logic [7:0]    rdata_q;
  logic          rd_ok_q;
  logic [7:0]    out_data_q;
  logic [3:0]    out_count_q;

  logic signed [10:0] xs, ys, lw, lh, px, py;
  logic [IW-1:0]      idx_full, rd_full;
  logic [1:0]         col_d;
  logic               on_screen;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         new_byte;

  always_comb begin
    xs = $signed({x_q[9], x_q}) + $signed({8'd0, step_q});
    ys = $signed({y_q[9], y_q});
    lw = rot_q[0] ? Height11 : Width11;
    lh = rot_q[0] ? Width11 : Height11;
    on_screen = !xs[10] && (xs < lw) && !ys[10] && (ys < lh);
    unique case (rot_q)
      2'd1: begin
        px = Width11 - 11'sd1 - ys;
        py = xs;
      end
      2'd2: begin
        px = Width11 - 11'sd1 - xs;
        py = Height11 - 11'sd1 - ys;
      end
      2'd3: begin
        px = ys;
        py = Height11 - 11'sd1 - xs;
      end
      default: begin
        px = xs;
        py = ys;
      end
    endcase
    idx_full = IW'(py[10:3]) * IW'(PANEL_WIDTH) + IW'(px[9:0]);
    if (op_q == OP_PIXEL) begin
      col_d = color_q;
    end else begin
      col_d = {1'b0, pattern_q[LastBit - step_q] ^ inv_q};
    end
    rd_full = IW'(bidx_q);
    rd_addr = (op_q == OP_READ) ? rd_full[AW-1:0] : idx_q;
    unique case (col_q)
      ColorBlack: new_byte = rdata_q & ~mask_q;
      ColorWhite: new_byte = rdata_q | mask_q;
      default:    new_byte = rdata_q ^ mask_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q       <= 2'd0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rot_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_we) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= op_e'(operation_i);
      x_q       <= pos_x_i;
      y_q       <= pos_y_i;
      color_q   <= color_i;
      pattern_q <= pattern_i;
      inv_q     <= invert_i;
      bidx_q    <= byte_index_i;
      step_q    <= 3'd0;
      count_q   <= 4'd0;
    end else begin
      if (cmd_i.step_inc) begin
        step_q <= step_q + 3'd1;
      end
      if (cmd_i.wr_en) begin
        count_q <= count_q + 4'd1;
      end
    end
    if (cmd_i.calc) begin
      idx_q  <= idx_full[AW-1:0];
      mask_q <= 8'd1 << py[2:0];
      col_q  <= col_d;
      hit_q  <= on_screen && (col_d != ColorNone);
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
      rd_ok_q <= rd_full < IW'(Depth);
    end
    if (cmd_i.clr_we) begin
      mem[clr_q] <= 8'd0;
    end else if (cmd_i.wr_en) begin
      mem[idx_q] <= new_byte;
    end
    if (cmd_i.out_load) begin
      out_data_q  <= (op_q == OP_READ && rd_ok_q) ? rdata_q : 8'd0;
      out_count_q <= count_q;
    end
  end

  assign sts_o.clr_last = clr_q == AW'(Depth - 1);
  assign sts_o.hit      = hit_q;
  assign sts_o.last     = (op_q != OP_BITMAP) || (step_q == LastBit);
  assign sts_o.is_read  = op_q == OP_READ;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_data_q;
  assign pixels_written_o = out_count_q;

endmodule

### design/pfpp_controller.sv
// ----------------------------------------------------------------------------
// Page framebuffer pixel plotter controller
// Sequences the clearing pass, operand capture, per-pixel read-modify-write
// and result hand-off.
// ----------------------------------------------------------------------------
module pfpp_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_op_i,
  output logic                in_ready_o,
  input  pfpp_pkg::ctrl_sts_t sts_i,
  output pfpp_pkg::ctrl_cmd_t cmd_o
);
  import pfpp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CALC  = 6'b000100,
    S_RD    = 6'b001000,
    S_WR    = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (op_e'(in_op_i))
            OP_PIXEL, OP_BITMAP: state_d = S_CALC;
            OP_READ:             state_d = S_RD;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_RD;
      end
      S_RD: begin
        if (sts_i.is_read) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_DONE;
        end else if (sts_i.hit) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_WR;
        end else if (sts_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step_inc = 1'b1;
          state_d        = S_CALC;
        end
      end
      S_WR: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step_inc = 1'b1;
          state_d        = S_CALC;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
